>>> design/approx_pattern_match_bitvector_top_assert.svh
// Assertion macros for the approximate pattern matcher.
// Included by the modules that carry concurrent checks; no other dependencies.
// Simulation builds get the checks, synthesis builds get empty bodies.
`ifndef APPROX_PATTERN_MATCH_BITVECTOR_TOP_ASSERT_SVH
`define APPROX_PATTERN_MATCH_BITVECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define APM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("apm check failed");

// Consequent must hold in the cycle after the antecedent.
`define APM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("apm check failed");

`else

`define APM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define APM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> design/apm_pkg.sv
// Shared types, codes and constants of the approximate pattern matcher.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package apm_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 7;
    localparam int MAXD_W     = 6;
    localparam int DIST_W     = 7;
    localparam int MDIST_W    = 6;
    localparam int END_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEXT  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORDS    = 2'd2;

    localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RST = 7'd1;
    localparam logic [MAXD_W-1:0] MAX_DISTANCE_RST   = 6'd2;
    // Limit after reset is min(2, 1 - 1) = 0, so the previous distance starts at 1
    localparam logic [DIST_W-1:0] PREV_DIST_RST      = 7'd1;
    localparam logic [DIST_W-1:0] SCORE_MAX          = 7'd127;

    typedef struct packed {
        logic [LEN_W-1:0]  eff_len;
        logic [DIST_W-1:0] eff_limit;
        logic              whole_words;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               match_found;
        logic [MDIST_W-1:0] match_distance;
        logic [END_W-1:0]   match_end;
    } t_result;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

`default_nettype wire

>>> design/apm_in_if.sv
// Request channel of the approximate pattern matcher: valid/ready plus command payload.
// Depends on apm_pkg for field widths.
`default_nettype none

interface apm_in_if;
    logic                         valid;
    logic                         ready;
    logic [apm_pkg::CMD_W-1:0]    cmd;
    logic [apm_pkg::CHAR_W-1:0]   char_code;
    logic [apm_pkg::POS_W-1:0]    pattern_pos;

    modport source (output valid, output cmd, output char_code, output pattern_pos,
                    input ready);
    modport sink   (input valid, input cmd, input char_code, input pattern_pos,
                    output ready);
endinterface

`default_nettype wire

>>> design/apm_out_if.sv
// Result channel of the approximate pattern matcher: valid/ready plus match payload.
// Depends on apm_pkg for field widths.
`default_nettype none

interface apm_out_if;
    logic                          valid;
    logic                          ready;
    logic [apm_pkg::DIST_W-1:0]    distance;
    logic                          match_found;
    logic [apm_pkg::MDIST_W-1:0]   match_distance;
    logic [apm_pkg::END_W-1:0]     match_end;

    modport source (output valid, output distance, output match_found,
                    output match_distance, output match_end, input ready);
    modport sink   (input valid, input distance, input match_found,
                    input match_distance, input match_end, output ready);
endinterface

`default_nettype wire

>>> design/apm_mask_tbl.sv
// Match-mask table: one pattern-position mask per byte value, registered read,
// read-modify-write set of one bit per load. Depends on apm_pkg.
`default_nettype none

module apm_mask_tbl #(
    parameter int PATTERN_BITS  = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [apm_pkg::CHAR_W-1:0]  i_rd_char,
    input  wire logic                        i_wr_en,
    input  wire logic [apm_pkg::CHAR_W-1:0]  i_wr_char,
    input  wire logic [apm_pkg::POS_W-1:0]   i_wr_pos,
    output logic      [PATTERN_BITS-1:0]     o_mask
);

    localparam int AW = $clog2(ALPHABET_SIZE);

    logic [PATTERN_BITS-1:0]  mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_vld;
    logic [PATTERN_BITS-1:0]  r_rd;
    logic                     r_rd_vld;
    logic                     r_in_range;
    logic                     r_byp;
    logic [PATTERN_BITS-1:0]  r_byp_data;

    logic                     rd_ok;
    logic                     wr_ok;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic [PATTERN_BITS-1:0]  wdata;

    assign raddr = i_rd_char[AW-1:0];
    assign waddr = i_wr_char[AW-1:0];
    assign rd_ok = ({1'b0, i_rd_char} < 9'(ALPHABET_SIZE));
    assign wr_ok = i_wr_en && ({1'b0, i_wr_char} < 9'(ALPHABET_SIZE))
                   && ({1'b0, i_wr_pos} < 7'(PATTERN_BITS));
    assign wdata = o_mask | (PATTERN_BITS'(1) << i_wr_pos);

    // Bytes beyond the alphabet and never-loaded entries read as all zero;
    // a write landing on the address being read in the same cycle is forwarded.
    always_comb begin
        if (!r_in_range) begin
            o_mask = '0;
        end else if (r_byp) begin
            o_mask = r_byp_data;
        end else if (r_rd_vld) begin
            o_mask = r_rd;
        end else begin
            o_mask = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[waddr] <= wdata;
        end
        if (i_rd_en && rd_ok) begin
            r_rd <= mem[raddr];
        end
        if (i_rd_en) begin
            r_byp_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_vld   <= 1'b0;
            r_in_range <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_in_range <= rd_ok;
                r_rd_vld   <= rd_ok ? r_vld[raddr] : 1'b0;
                r_byp      <= wr_ok && (waddr == raddr);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/apm_myers_core.sv
// Myers bit-vector recurrence, score tracking, local-optimum match reporting
// and line position. Depends on apm_pkg and the assertion macro header.
`default_nettype none
`include "approx_pattern_match_bitvector_top_assert.svh"

module apm_myers_core #(
    parameter int PATTERN_BITS = 64,
    parameter int LINE_LIMIT   = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire apm_pkg::t_cmd               i_cmd,
    input  wire logic [apm_pkg::CHAR_W-1:0]  i_char,
    input  wire logic [PATTERN_BITS-1:0]     i_mask,
    input  wire apm_pkg::t_cfg               i_cfg,
    output apm_pkg::t_result                 o_res
);

    localparam int IW  = $clog2(PATTERN_BITS);
    localparam int LPW = $clog2(LINE_LIMIT);
    localparam logic [LPW-1:0] LINE_LAST = LPW'(LINE_LIMIT - 1);

    logic [PATTERN_BITS-1:0]     r_pv, n_pv;
    logic [PATTERN_BITS-1:0]     r_mv, n_mv;
    logic [apm_pkg::DIST_W-1:0]  r_score, n_score;
    logic [apm_pkg::DIST_W-1:0]  r_prev, n_prev;
    logic                        r_pending, n_pending;
    logic [LPW-1:0]              r_line_pos, n_line_pos;

    logic [PATTERN_BITS-1:0]     xv, xh, ph, mh, ph_s, pv_step, mv_step;
    logic [IW-1:0]               top_idx;
    logic [apm_pkg::DIST_W-1:0]  score_step;
    logic [LPW-1:0]              prev_end;
    logic                        report_ok;

    assign top_idx = IW'(i_cfg.eff_len - 7'd1);
    assign xv      = i_mask | r_mv;
    assign xh      = (((i_mask & r_pv) + r_pv) ^ r_pv) | i_mask;
    assign ph      = r_mv | ~(xh | r_pv);
    assign mh      = r_pv & xh;
    // Whole-words mode shifts in ones so a match must open at a word start
    assign ph_s    = {ph[PATTERN_BITS-2:0], i_cfg.whole_words};
    assign pv_step = {mh[PATTERN_BITS-2:0], 1'b0} | ~(xv | ph_s);
    assign mv_step = ph_s & xv;

    assign prev_end  = (r_line_pos != '0) ? (r_line_pos - LPW'(1)) : '0;
    assign report_ok = (r_prev <= i_cfg.eff_limit) && r_pending;

    always_comb begin
        score_step = r_score;
        if (ph[top_idx]) begin
            if (r_score != apm_pkg::SCORE_MAX) begin
                score_step = r_score + 7'd1;
            end
        end else if (mh[top_idx]) begin
            if (r_score != '0) begin
                score_step = r_score - 7'd1;
            end
        end
    end

    always_comb begin
        n_pv       = r_pv;
        n_mv       = r_mv;
        n_score    = r_score;
        n_prev     = r_prev;
        n_pending  = r_pending;
        n_line_pos = r_line_pos;
        o_res      = '0;
        case (i_cmd)
            apm_pkg::CMD_LOAD: begin
            end
            apm_pkg::CMD_START: begin
                n_pv       = '1;
                n_mv       = '0;
                n_score    = i_cfg.eff_len;
                n_prev     = i_cfg.eff_limit + 7'd1;
                n_pending  = 1'b0;
                n_line_pos = '0;
            end
            apm_pkg::CMD_END: begin
                if (report_ok) begin
                    o_res.match_found    = 1'b1;
                    o_res.match_distance = r_prev[apm_pkg::MDIST_W-1:0];
                    o_res.match_end      = apm_pkg::END_W'(prev_end);
                end
                n_pending = 1'b0;
            end
            apm_pkg::CMD_TEXT: begin
                o_res.distance = score_step;
                n_pv           = pv_step;
                n_mv           = mv_step;
                n_score        = score_step;
                if (i_cfg.whole_words) begin
                    if (!apm_pkg::is_alnum(i_char)) begin
                        // Word break: flush a pending match and restart the search
                        if (report_ok) begin
                            o_res.match_found    = 1'b1;
                            o_res.match_distance = r_prev[apm_pkg::MDIST_W-1:0];
                            o_res.match_end      = apm_pkg::END_W'(prev_end);
                        end
                        n_pv      = '1;
                        n_mv      = '0;
                        n_score   = i_cfg.eff_len;
                        n_pending = 1'b0;
                    end else if (score_step < r_prev) begin
                        n_pending = 1'b1;
                    end
                end else begin
                    // Report at the end of a run of falling distances
                    if ((r_prev < score_step) && report_ok) begin
                        o_res.match_found    = 1'b1;
                        o_res.match_distance = r_prev[apm_pkg::MDIST_W-1:0];
                        o_res.match_end      = apm_pkg::END_W'(prev_end);
                        n_pending            = 1'b0;
                    end else if (score_step < r_prev) begin
                        n_pending = 1'b1;
                    end
                end
                n_prev = score_step;
                if (r_line_pos != LINE_LAST) begin
                    n_line_pos = r_line_pos + LPW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= '1;
            r_mv       <= '0;
            r_score    <= apm_pkg::PATTERN_LENGTH_RST;
            r_prev     <= apm_pkg::PREV_DIST_RST;
            r_pending  <= 1'b0;
            r_line_pos <= '0;
        end else if (i_fire) begin
            r_pv       <= n_pv;
            r_mv       <= n_mv;
            r_score    <= n_score;
            r_prev     <= n_prev;
            r_pending  <= n_pending;
            r_line_pos <= n_line_pos;
        end
    end

    `APM_ASSERT_SAME(a_found_needs_pending, i_clk, i_rst_n, i_fire && o_res.match_found, r_pending)
    `APM_ASSERT_NEXT(a_start_clears_line, i_clk, i_rst_n, i_fire && (i_cmd == apm_pkg::CMD_START), (r_line_pos == '0) && !r_pending)

endmodule

`default_nettype wire

>>> design/approx_pattern_match_bitvector_top.sv
// Approximate pattern matcher, top level: config registers, request register,
// mask table, recurrence core and result register. Depends on apm_pkg,
// apm_in_if, apm_out_if, apm_mask_tbl, apm_myers_core and the assertion header.
// Path: request register, then result register; the mask is read as the request is accepted.
// Throughput: one request per cycle if results are taken; the 64-bit add sets the clock.
// Reset: synchronous, active low; clears state and all mask valid bits at once, no sweep.
`default_nettype none
`include "approx_pattern_match_bitvector_top_assert.svh"

module approx_pattern_match_bitvector_top #(
    parameter int PATTERN_BITS  = 64,
    parameter int ALPHABET_SIZE = 256,
    parameter int LINE_LIMIT    = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    apm_in_if.sink                               i_req,
    apm_out_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [apm_pkg::LEN_W-1:0]   r_pattern_length;
    logic [apm_pkg::MAXD_W-1:0]  r_max_distance;
    logic                        r_whole_words;

    logic                        r_s1_valid;
    apm_pkg::t_cmd               r_s1_cmd;
    logic [apm_pkg::CHAR_W-1:0]  r_s1_char;
    logic [apm_pkg::POS_W-1:0]   r_s1_pos;

    logic                        r_out_valid;
    apm_pkg::t_result            r_out;

    apm_pkg::t_cfg               cfg;
    apm_pkg::t_result            core_res;
    logic [PATTERN_BITS-1:0]     mask;
    logic [apm_pkg::LEN_W-1:0]   cap;
    logic                        accept;
    logic                        s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= apm_pkg::PATTERN_LENGTH_RST;
            r_max_distance   <= apm_pkg::MAX_DISTANCE_RST;
            r_whole_words    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                apm_pkg::CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data;
                apm_pkg::CFG_MAX_DISTANCE:   r_max_distance   <= i_cfg_data[apm_pkg::MAXD_W-1:0];
                apm_pkg::CFG_WHOLE_WORDS:    r_whole_words    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the pattern length into 1..PATTERN_BITS, the limit to length minus one
    always_comb begin
        if (r_pattern_length == '0) begin
            cfg.eff_len = 7'd1;
        end else if (r_pattern_length > 7'(PATTERN_BITS)) begin
            cfg.eff_len = 7'(PATTERN_BITS);
        end else begin
            cfg.eff_len = r_pattern_length;
        end
        cap = cfg.eff_len - 7'd1;
        cfg.eff_limit   = ({1'b0, r_max_distance} < cap) ? {1'b0, r_max_distance} : cap;
        cfg.whole_words = r_whole_words;
    end

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= apm_pkg::t_cmd'(i_req.cmd);
            r_s1_char <= i_req.char_code;
            r_s1_pos  <= i_req.pattern_pos;
        end
    end

    apm_mask_tbl #(
        .PATTERN_BITS  (PATTERN_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_mask_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_char (i_req.char_code),
        .i_wr_en   (s1_fire && (r_s1_cmd == apm_pkg::CMD_LOAD)),
        .i_wr_char (r_s1_char),
        .i_wr_pos  (r_s1_pos),
        .o_mask    (mask)
    );

    apm_myers_core #(
        .PATTERN_BITS (PATTERN_BITS),
        .LINE_LIMIT   (LINE_LIMIT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_cmd   (r_s1_cmd),
        .i_char  (r_s1_char),
        .i_mask  (mask),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Hold the result until taken; load a new one whenever the request stage fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= core_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.distance       = r_out.distance;
    assign o_rsp.match_found    = r_out.match_found;
    assign o_rsp.match_distance = r_out.match_distance;
    assign o_rsp.match_end      = r_out.match_end;

    `APM_ASSERT_SAME(a_match_within_limit, i_clk, i_rst_n, r_out_valid && r_out.match_found, {1'b0, r_out.match_distance} <= cfg.eff_limit)

endmodule

`default_nettype wire

>>> tb/approx_pattern_match_bitvector_top_tb.sv
// Self-checking bench for approx_pattern_match_bitvector_top: a queue-fed driver, a
// monitor and a bit-parallel edit-distance predictor compared item by item.
// Depends on apm_pkg, apm_in_if, apm_out_if and the top level.
module approx_pattern_match_bitvector_top_tb;
    import apm_pkg::*;

    localparam int LINE_CAP     = 4095;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ITEM_TARGET  = 1300;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  pos;
    } t_req;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    apm_in_if  req_if ();
    apm_out_if rsp_if ();

    approx_pattern_match_bitvector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_req    pending_requests[$];
    t_result expected_reports[$];
    t_req    on_bus;
    int      items_queued;
    int      mismatch_count;
    int      cycle_count;

    // predictor state
    logic [63:0]       hit_masks [256];
    logic [63:0]       vp;
    logic [63:0]       vn;
    int                run_score;
    int                last_dist;
    bit                match_armed;
    int                text_pos;
    logic [LEN_W-1:0]  cfg_len;
    logic [MAXD_W-1:0] cfg_maxd;
    bit                cfg_ww;

    // stimulus shaping
    logic [CHAR_W-1:0] letters [4];
    logic [CHAR_W-1:0] pattern_bytes[$];

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit word_char(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic int used_length();
        if (cfg_len == 0) return 1;
        if (cfg_len > 64) return 64;
        return int'(cfg_len);
    endfunction

    function automatic int report_limit();
        int cap;
        cap = used_length() - 1;
        return (int'(cfg_maxd) < cap) ? int'(cfg_maxd) : cap;
    endfunction

    function automatic void restart_columns();
        run_score = used_length();
        vp = '1;
        vn = '0;
    endfunction

    // One column of the bit-parallel recurrence; returns the new score.
    function automatic int step_text(input logic [CHAR_W-1:0] c);
        logic [63:0] top, eq, xv, xh, ph, mh;
        top = 64'd1 << (used_length() - 1);
        eq  = hit_masks[c];
        xv  = eq | vn;
        xh  = (((eq & vp) + vp) ^ vp) | eq;
        ph  = vn | ~(xh | vp);
        mh  = vp & xh;
        if ((ph & top) != 0) begin
            if (run_score < 127) run_score++;
        end else if ((mh & top) != 0) begin
            if (run_score > 0) run_score--;
        end
        ph = ph << 1;
        if (cfg_ww) ph[0] = 1'b1;
        vp = (mh << 1) | ~(xv | ph);
        vn = ph & xv;
        return run_score;
    endfunction

    function automatic void mark_match(inout t_result res, input int prev_end);
        res.match_found    = 1'b1;
        res.match_distance = MDIST_W'(last_dist);
        res.match_end      = END_W'(prev_end);
    endfunction

    function automatic t_result predict_report(input t_req r);
        t_result res;
        int lim, prev_end, d;
        res      = '0;
        lim      = report_limit();
        prev_end = (text_pos > 0) ? text_pos - 1 : 0;
        case (r.cmd)
            CMD_LOAD: begin
                hit_masks[r.char_code][r.pos] = 1'b1;
            end
            CMD_START: begin
                restart_columns();
                last_dist   = lim + 1;
                match_armed = 1'b0;
                text_pos    = 0;
            end
            CMD_END: begin
                if (last_dist <= lim && match_armed) mark_match(res, prev_end);
                match_armed = 1'b0;
            end
            default: begin
                d = step_text(r.char_code);
                res.distance = DIST_W'(d);
                if (cfg_ww) begin
                    if (!word_char(r.char_code)) begin
                        if (last_dist <= lim && match_armed) mark_match(res, prev_end);
                        restart_columns();
                        match_armed = 1'b0;
                    end else if (d < last_dist) begin
                        match_armed = 1'b1;
                    end
                end else begin
                    if (last_dist < d && last_dist <= lim && match_armed) begin
                        mark_match(res, prev_end);
                        match_armed = 1'b0;
                    end else if (d < last_dist) begin
                        match_armed = 1'b1;
                    end
                end
                last_dist = d;
                if (text_pos < LINE_CAP) text_pos++;
            end
        endcase
        return res;
    endfunction

    // Request driver: one request per handshake, random gaps between requests.
    int gap_left;
    bit src_quiet;
    always @(posedge i_clk) begin : drive_requests
        bit presenting;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            presenting = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                expected_reports.push_back(predict_report(on_bus));
                presenting = 1'b0;
                gap_left   = src_quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 49) == 0) src_quiet = !src_quiet;
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    on_bus = pending_requests.pop_front();
                    req_if.cmd         <= on_bus.cmd;
                    req_if.char_code   <= on_bus.char_code;
                    req_if.pattern_pos <= on_bus.pos;
                    presenting = 1'b1;
                end
            end
            req_if.valid <= presenting;
        end
    end

    // Result monitor: stall the result channel at random, compare every report.
    int stall_left;
    bit sink_quiet;
    always @(posedge i_clk) begin : check_reports
        t_result want, got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.distance       = rsp_if.distance;
                got.match_found    = rsp_if.match_found;
                got.match_distance = rsp_if.match_distance;
                got.match_end      = rsp_if.match_end;
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected report: dist %0d found %0d mdist %0d end %0d",
                             $time, got.distance, got.match_found, got.match_distance,
                             got.match_end);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.distance !== want.distance ||
                        got.match_found !== want.match_found ||
                        got.match_distance !== want.match_distance ||
                        got.match_end !== want.match_end) begin
                        mismatch_count++;
                        $display("%0t mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $time, want.distance, want.match_found,
                                 want.match_distance, want.match_end, got.distance,
                                 got.match_found, got.match_distance, got.match_end);
                    end
                end
                stall_left = sink_quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 49) == 0) sink_quiet = !sink_quiet;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input t_cmd cmd, input logic [CHAR_W-1:0] c,
                                 input logic [POS_W-1:0] pos);
        t_req r;
        r.cmd       = cmd;
        r.char_code = c;
        r.pos       = pos;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    // Hold until every request has gone and every report has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || req_if.valid ||
               expected_reports.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: cfg_len  = data;
            CFG_MAX_DISTANCE:   cfg_maxd = data[MAXD_W-1:0];
            CFG_WHOLE_WORDS:    cfg_ww   = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [LEN_W-1:0] len, input logic [MAXD_W-1:0] maxd,
                               input bit ww);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_MAX_DISTANCE, {1'b0, maxd});
        write_reg(CFG_WHOLE_WORDS, {6'd0, ww});
    endtask

    // Prefer bytes whose masks are still clear so that each pattern stays distinct.
    task automatic pick_letters(input bit ww);
        logic [CHAR_W-1:0] c;
        int got, tries;
        bit dup;
        got   = 0;
        tries = 0;
        while (got < 4) begin
            c = CHAR_W'($urandom_range(0, 255));
            tries++;
            dup = 1'b0;
            for (int j = 0; j < got; j++) if (letters[j] == c) dup = 1'b1;
            if (!dup && word_char(c) == ww && (hit_masks[c] == '0 || tries > 2000)) begin
                letters[got] = c;
                got++;
            end
        end
    endtask

    task automatic push_segment(input bit ww, output int n);
        logic [CHAR_W-1:0] piece[$];
        logic [CHAR_W-1:0] c;
        int pick, at;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            // pattern copy with a few edits
            foreach (pattern_bytes[i]) piece.push_back(pattern_bytes[i]);
            repeat ($urandom_range(0, 3)) begin
                if (piece.size() == 0) begin
                    piece.push_back(letters[$urandom_range(0, 3)]);
                end else begin
                    at = $urandom_range(0, piece.size() - 1);
                    case ($urandom_range(0, 2))
                        0: piece[at] = letters[$urandom_range(0, 3)];
                        1: piece.delete(at);
                        default: piece.insert(at, letters[$urandom_range(0, 3)]);
                    endcase
                end
            end
        end else if (pick < 15) begin
            repeat ($urandom_range(1, 6)) piece.push_back(letters[$urandom_range(0, 3)]);
        end else if (pick < 18) begin
            c = CHAR_W'($urandom_range(0, 255));
            while (ww && word_char(c)) c = CHAR_W'($urandom_range(0, 255));
            piece.push_back(c);
        end else begin
            repeat ($urandom_range(1, 3)) piece.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        foreach (piece[i]) queue_request(CMD_TEXT, piece[i], POS_W'($urandom_range(0, 63)));
        n = piece.size();
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input logic [MAXD_W-1:0] maxd,
                             input bit ww, input int lines, input int min_text);
        int plen, count, n, want_text;
        apply_setup(len, maxd, ww);
        plen = used_length();
        pick_letters(ww);
        pattern_bytes = {};
        repeat (plen) pattern_bytes.push_back(letters[$urandom_range(0, 3)]);
        foreach (pattern_bytes[i]) queue_request(CMD_LOAD, pattern_bytes[i], POS_W'(i));
        // stray bits above the score bit still feed the carry chain
        if (plen < 64 && $urandom_range(0, 3) == 0)
            queue_request(CMD_LOAD, letters[$urandom_range(0, 3)],
                          POS_W'($urandom_range(plen, 63)));
        repeat (lines) begin
            if ($urandom_range(0, 9) != 0)
                queue_request(CMD_START, CHAR_W'($urandom_range(0, 255)),
                              POS_W'($urandom_range(0, 63)));
            want_text = (min_text > 0) ? min_text : $urandom_range(1, 2 * plen + 12);
            count = 0;
            while (count < want_text) begin
                push_segment(ww, n);
                count += n;
            end
            if ($urandom_range(0, 9) != 0)
                queue_request(CMD_END, CHAR_W'($urandom_range(0, 255)),
                              POS_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 4) == 0) queue_request(CMD_END, 8'h00, 6'd0);
            if ($urandom_range(0, 19) == 0)
                queue_request(t_cmd'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                              POS_W'($urandom_range(0, 63)));
        end
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0]  len;
        logic [MAXD_W-1:0] maxd;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        foreach (hit_masks[i]) hit_masks[i] = '0;
        cfg_len  = PATTERN_LENGTH_RST;
        cfg_maxd = MAX_DISTANCE_RST;
        cfg_ww   = 1'b0;
        restart_columns();
        last_dist   = report_limit() + 1;
        match_armed = 1'b0;
        text_pos    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: text before any line start, then a one-byte pattern.
        queue_request(CMD_TEXT, 8'h00, 6'd0);
        queue_request(CMD_END, 8'h00, 6'd0);
        queue_request(CMD_LOAD, 8'hFF, 6'd63);
        queue_request(CMD_LOAD, 8'h41, 6'd0);
        queue_request(CMD_START, 8'hFF, 6'd63);
        queue_request(CMD_TEXT, 8'h78, 6'd0);
        queue_request(CMD_TEXT, 8'h41, 6'd63);
        queue_request(CMD_TEXT, 8'h78, 6'd0);
        queue_request(CMD_TEXT, 8'hFF, 6'd0);
        queue_request(CMD_TEXT, 8'h41, 6'd0);
        queue_request(CMD_END, 8'h00, 6'd0);
        queue_request(CMD_END, 8'h00, 6'd0);

        // Whole words, distance cap above the pattern length.
        apply_setup(7'd3, 6'd63, 1'b1);
        queue_request(CMD_LOAD, 8'h61, 6'd0);
        queue_request(CMD_LOAD, 8'h62, 6'd1);
        queue_request(CMD_LOAD, 8'h31, 6'd2);
        queue_request(CMD_START, 8'h00, 6'd0);
        queue_request(CMD_TEXT, 8'h61, 6'd0);
        queue_request(CMD_TEXT, 8'h62, 6'd0);
        queue_request(CMD_TEXT, 8'h31, 6'd0);
        queue_request(CMD_TEXT, 8'h2D, 6'd0);
        queue_request(CMD_TEXT, 8'h61, 6'd0);
        queue_request(CMD_TEXT, 8'h62, 6'd0);
        queue_request(CMD_END, 8'h00, 6'd0);

        // Zero length acts as one; oversize acts as the full width.
        apply_setup(7'd0, 6'd0, 1'b0);
        queue_request(CMD_TEXT, 8'h41, 6'd0);
        queue_request(CMD_TEXT, 8'h42, 6'd0);
        apply_setup(7'd127, 6'd5, 1'b0);
        queue_request(CMD_START, 8'h00, 6'd0);
        queue_request(CMD_TEXT, 8'hFF, 6'd0);
        queue_request(CMD_END, 8'h00, 6'd0);

        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len = 7'd1;
                1:       len = 7'd64;
                2:       len = 7'd0;
                3:       len = LEN_W'($urandom_range(65, 127));
                4:       len = LEN_W'($urandom_range(20, 63));
                default: len = LEN_W'($urandom_range(2, 10));
            endcase
            case ($urandom_range(0, 5))
                0:       maxd = 6'd0;
                1:       maxd = 6'd63;
                default: maxd = MAXD_W'($urandom_range(0, 4));
            endcase
            run_phase(len, maxd, $urandom_range(0, 2) == 0, $urandom_range(2, 5), 0);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
